/* hdl/text_console_framebuffer_unit_defines.svh */
// assertion macros used by the console framebuffer controller
`ifndef TEXT_CONSOLE_FRAMEBUFFER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_FRAMEBUFFER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tcfb_pkg.sv */
// types, constants and codes of the text console framebuffer
package tcfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int GLYPH_WIDTH_DEF   = 8;
    localparam int GLYPH_HEIGHT_DEF  = 16;
    localparam int LINE_GAP_DEF      = 0;
    localparam int CHAR_GAP_DEF      = 0;

    localparam int COORD_W    = 12;
    localparam int ADDR_FULLW = 24;
    localparam int FONT_DEPTH = 1520;
    localparam int FONT_AW    = 11;
    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;
    localparam logic [10:0] STRIDE_RESET = 11'd640;

    typedef enum logic [3:0] {
        KIND_PUT     = 4'd0,
        KIND_NEWLINE = 4'd1,
        KIND_ERASE   = 4'd2,
        KIND_CLEAR   = 4'd3,
        KIND_SETCUR  = 4'd4,
        KIND_WRPX    = 4'd5,
        KIND_RDPX    = 4'd6,
        KIND_FILL    = 4'd7,
        KIND_FONT    = 4'd8,
        KIND_CHARAT  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        CFG_SCAN_STRIDE = 3'd0,
        CFG_CLIP_ON     = 3'd1,
        CFG_CLIP_X      = 3'd2,
        CFG_CLIP_Y      = 3'd3,
        CFG_CLIP_W      = 3'd4,
        CFG_CLIP_H      = 3'd5,
        CFG_CLIP_BG     = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PC_CHK1,
        S_PC_CHK2,
        S_PC_DRAW,
        S_NL_START,
        S_NL_LOOP,
        S_ROW,
        S_PIX,
        S_CPW,
        S_WEND,
        S_RD,
        S_RDW,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        W_RAW,
        W_CLIPPED,
        W_GLYPH,
        W_COPY
    } walk_mode_t;

    typedef enum logic [1:0] {
        RET_DONE,
        RET_CHK2,
        RET_DRAW
    } ret_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [10:0] rect_w;
        logic [10:0] rect_h;
        logic [7:0]  char_code;
        logic [31:0] color;
        logic [3:0]  font_row;
        logic [7:0]  font_bits;
    } cmd_t;

    typedef struct packed {
        logic [10:0] scan_stride;
        logic        clip_on;
        logic [9:0]  clip_x;
        logic [8:0]  clip_y;
        logic [9:0]  clip_w;
        logic [8:0]  clip_h;
        logic [31:0] clip_background;
    } cfg_t;

    typedef struct packed {
        logic                done;
        logic [31:0]         pixel_value;
        logic [10:0]         cursor_x;
        logic [10:0]         cursor_y;
        logic                scrolled;
    } res_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [FONT_AW-1:0]  addr;
        logic [7:0]          wdata;
    } font_req_t;

endpackage

/* hdl/tcfb_spram.sv */
// single-port synchronous ram with registered read data
module tcfb_spram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

/* hdl/tcfb_ctrl.sv */
// command sequencer: cursor logic, new line, and the pixel walk over the frame store
`include "text_console_framebuffer_unit_defines.svh"

module tcfb_ctrl #(
    parameter int SCREEN_WIDTH  = tcfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_WIDTH   = tcfb_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT  = tcfb_pkg::GLYPH_HEIGHT_DEF,
    parameter int LINE_GAP      = tcfb_pkg::LINE_GAP_DEF,
    parameter int CHAR_GAP      = tcfb_pkg::CHAR_GAP_DEF,
    parameter int FS_DEPTH      = SCREEN_HEIGHT * 1024,
    parameter int FS_AW         = $clog2(FS_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tcfb_pkg::cmd_t        cmd,
    input  tcfb_pkg::cfg_t        cfg,
    output logic                  busy,
    output tcfb_pkg::res_t        res,
    output logic                  fs_en,
    output logic                  fs_we,
    output logic [FS_AW-1:0]      fs_addr,
    output logic [31:0]           fs_wdata,
    input  logic [31:0]           fs_q,
    output tcfb_pkg::font_req_t   font_req,
    input  logic [7:0]            font_q
);

    localparam int CW = tcfb_pkg::COORD_W;
    localparam int AFW = tcfb_pkg::ADDR_FULLW;
    localparam logic [CW-1:0] SW_C   = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0] SH_C   = CW'(SCREEN_HEIGHT);
    localparam logic [CW-1:0] GW_C   = CW'(GLYPH_WIDTH);
    localparam logic [CW-1:0] GH_C   = CW'(GLYPH_HEIGHT);
    localparam logic [CW-1:0] LH_C   = CW'(GLYPH_HEIGHT + LINE_GAP);
    localparam logic [CW-1:0] STEP_C = CW'(GLYPH_WIDTH + CHAR_GAP);
    localparam logic [2:0]    GWM1   = 3'(GLYPH_WIDTH - 1);
    localparam logic [AFW-1:0] DEPTH_C = AFW'(FS_DEPTH);

    tcfb_pkg::state_t     state_reg, state_next;
    tcfb_pkg::cmd_t       cmd_reg, cmd_next;
    logic [10:0]          col_reg, col_next;
    logic [10:0]          row_reg, row_next;
    logic [31:0]          bg_reg, bg_next;
    logic [31:0]          pix_reg, pix_next;
    logic                 scr_reg, scr_next;
    tcfb_pkg::ret_t       ret_reg, ret_next;
    logic                 nlw_reg, nlw_next;
    logic [CW-1:0]        nl_row_reg, nl_row_next;
    logic [CW-1:0]        sacc_reg, sacc_next;
    tcfb_pkg::walk_mode_t wmode_reg, wmode_next;
    logic [CW-1:0]        wx0_reg, wx0_next;
    logic [CW-1:0]        wy0_reg, wy0_next;
    logic [CW-1:0]        ww_reg, ww_next;
    logic [CW-1:0]        wh_reg, wh_next;
    logic [CW-1:0]        c_reg, c_next;
    logic [CW-1:0]        r_reg, r_next;
    logic [CW-1:0]        s_reg, s_next;
    logic [31:0]          wcolor_reg, wcolor_next;
    logic                 rdok_reg, rdok_next;
    tcfb_pkg::res_t       res_reg, res_next;

    tcfb_pkg::kind_t      kind;
    logic                 printable;
    logic [CW-1:0]        ax, ay, cur_x, cur_y;
    logic [AFW-1:0]       addr_full;
    logic                 addr_ok, on_scr, glyph_bit;
    logic [CW-1:0]        maxx, maxy, limit, minx;
    logic [CW-1:0]        s_scr, s_clip, w_avail, h_avail, fill_w, fill_h;
    logic [CW:0]          nl_sum;
    tcfb_pkg::state_t     ret_state;
    logic [6:0]           glyph_base;
    logic                 last_col;

    assign kind       = tcfb_pkg::kind_t'(cmd_reg.kind);
    assign printable  = (cmd_reg.char_code >= tcfb_pkg::CODE_FIRST)
                     && (cmd_reg.char_code <= tcfb_pkg::CODE_LAST);
    assign glyph_base = 7'(cmd_reg.char_code - tcfb_pkg::CODE_FIRST);

    assign cur_x = wx0_reg + c_reg;
    assign cur_y = wy0_reg + r_reg;

    // one shared address multiplier for every frame store access
    always_comb
    begin
        ax = cur_x;
        ay = cur_y;
        if (state_reg == tcfb_pkg::S_RD)
        begin
            ax = CW'(cmd_reg.pos_x);
            ay = CW'(cmd_reg.pos_y);
        end
        else if (state_reg == tcfb_pkg::S_PIX && wmode_reg == tcfb_pkg::W_COPY)
            ay = cur_y + s_reg;
    end

    assign addr_full = (AFW'(ay) * AFW'(cfg.scan_stride)) + AFW'(ax);
    assign addr_ok   = addr_full < DEPTH_C;
    assign on_scr    = (ax < SW_C) && (ay < SH_C);
    assign glyph_bit = font_q[GWM1 - c_reg[2:0]];
    assign last_col  = (c_reg + CW'(1)) >= ww_reg;

    assign maxx  = cfg.clip_on ? CW'(cfg.clip_x) + CW'(cfg.clip_w) : SW_C;
    assign maxy  = cfg.clip_on ? CW'(cfg.clip_y) + CW'(cfg.clip_h) : SH_C;
    assign limit = maxy;
    assign minx  = cfg.clip_on ? CW'(cfg.clip_x) : '0;
    assign nl_sum = (CW+1)'(nl_row_reg) + (CW+1)'(GH_C);

    assign s_scr  = (sacc_reg < SH_C) ? sacc_reg : SH_C;
    assign s_clip = (sacc_reg < CW'(cfg.clip_h)) ? sacc_reg : CW'(cfg.clip_h);

    assign w_avail = SW_C - CW'(cmd_reg.pos_x);
    assign h_avail = SH_C - CW'(cmd_reg.pos_y);
    assign fill_w  = (CW'(cmd_reg.pos_x) >= SW_C) ? '0
                   : ((CW'(cmd_reg.rect_w) < w_avail) ? CW'(cmd_reg.rect_w) : w_avail);
    assign fill_h  = (CW'(cmd_reg.pos_y) >= SH_C) ? '0
                   : ((CW'(cmd_reg.rect_h) < h_avail) ? CW'(cmd_reg.rect_h) : h_avail);

    always_comb
    begin
        unique case (ret_reg)
            tcfb_pkg::RET_CHK2: ret_state = tcfb_pkg::S_PC_CHK2;
            tcfb_pkg::RET_DRAW: ret_state = tcfb_pkg::S_PC_DRAW;
            default:            ret_state = tcfb_pkg::S_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcfb_pkg::S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            bg_reg    <= '0;
            ret_reg   <= tcfb_pkg::RET_DONE;
            nlw_reg   <= 1'b0;
            wmode_reg <= tcfb_pkg::W_RAW;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            bg_reg    <= bg_next;
            ret_reg   <= ret_next;
            nlw_reg   <= nlw_next;
            wmode_reg <= wmode_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pix_reg    <= pix_next;
        scr_reg    <= scr_next;
        nl_row_reg <= nl_row_next;
        sacc_reg   <= sacc_next;
        wx0_reg    <= wx0_next;
        wy0_reg    <= wy0_next;
        ww_reg     <= ww_next;
        wh_reg     <= wh_next;
        c_reg      <= c_next;
        r_reg      <= r_next;
        s_reg      <= s_next;
        wcolor_reg <= wcolor_next;
        rdok_reg   <= rdok_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bg_next     = bg_reg;
        pix_next    = pix_reg;
        scr_next    = scr_reg;
        ret_next    = ret_reg;
        nlw_next    = nlw_reg;
        nl_row_next = nl_row_reg;
        sacc_next   = sacc_reg;
        wmode_next  = wmode_reg;
        wx0_next    = wx0_reg;
        wy0_next    = wy0_reg;
        ww_next     = ww_reg;
        wh_next     = wh_reg;
        c_next      = c_reg;
        r_next      = r_reg;
        s_next      = s_reg;
        wcolor_next = wcolor_reg;
        rdok_next   = rdok_reg;
        res_next    = '0;
        fs_en       = 1'b0;
        fs_we       = 1'b0;
        fs_wdata    = wcolor_reg;
        font_req    = '0;

        unique case (state_reg)
            tcfb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = tcfb_pkg::S_DECODE;
                end
            end

            tcfb_pkg::S_DECODE:
            begin
                pix_next   = '0;
                scr_next   = 1'b0;
                nlw_next   = 1'b0;
                ret_next   = tcfb_pkg::RET_DONE;
                c_next     = '0;
                r_next     = '0;
                state_next = tcfb_pkg::S_DONE;
                unique case (kind)
                    tcfb_pkg::KIND_PUT:
                    begin
                        if (printable)
                        begin
                            if (cfg.clip_on)
                            begin
                                if (col_reg < 11'(cfg.clip_x))
                                    col_next = 11'(cfg.clip_x);
                                if (row_reg < 11'(cfg.clip_y))
                                    row_next = 11'(cfg.clip_y);
                            end
                            state_next = tcfb_pkg::S_PC_CHK1;
                        end
                    end
                    tcfb_pkg::KIND_NEWLINE:
                        state_next = tcfb_pkg::S_NL_START;
                    tcfb_pkg::KIND_ERASE:
                    begin
                        if (CW'(col_reg) >= minx + STEP_C)
                        begin
                            col_next    = col_reg - 11'(STEP_C);
                            wmode_next  = tcfb_pkg::W_CLIPPED;
                            wx0_next    = CW'(col_reg) - STEP_C;
                            wy0_next    = CW'(row_reg);
                            ww_next     = STEP_C;
                            wh_next     = GH_C;
                            wcolor_next = bg_reg;
                            state_next  = tcfb_pkg::S_ROW;
                        end
                    end
                    tcfb_pkg::KIND_CLEAR:
                    begin
                        col_next    = '0;
                        row_next    = '0;
                        bg_next     = cmd_reg.color;
                        wmode_next  = tcfb_pkg::W_RAW;
                        wx0_next    = '0;
                        wy0_next    = '0;
                        ww_next     = SW_C;
                        wh_next     = SH_C;
                        wcolor_next = cmd_reg.color;
                        state_next  = tcfb_pkg::S_ROW;
                    end
                    tcfb_pkg::KIND_SETCUR:
                    begin
                        col_next = 11'(cmd_reg.pos_x);
                        row_next = 11'(cmd_reg.pos_y);
                    end
                    tcfb_pkg::KIND_WRPX:
                    begin
                        wmode_next  = tcfb_pkg::W_CLIPPED;
                        wx0_next    = CW'(cmd_reg.pos_x);
                        wy0_next    = CW'(cmd_reg.pos_y);
                        ww_next     = CW'(1);
                        wh_next     = CW'(1);
                        wcolor_next = cmd_reg.color;
                        state_next  = tcfb_pkg::S_ROW;
                    end
                    tcfb_pkg::KIND_RDPX:
                        state_next = tcfb_pkg::S_RD;
                    tcfb_pkg::KIND_FILL:
                    begin
                        wmode_next  = tcfb_pkg::W_CLIPPED;
                        wx0_next    = CW'(cmd_reg.pos_x);
                        wy0_next    = CW'(cmd_reg.pos_y);
                        ww_next     = fill_w;
                        wh_next     = fill_h;
                        wcolor_next = cmd_reg.color;
                        state_next  = tcfb_pkg::S_ROW;
                    end
                    tcfb_pkg::KIND_FONT:
                    begin
                        if (printable)
                        begin
                            font_req.en    = 1'b1;
                            font_req.we    = 1'b1;
                            font_req.addr  = {glyph_base, cmd_reg.font_row};
                            font_req.wdata = cmd_reg.font_bits;
                        end
                    end
                    tcfb_pkg::KIND_CHARAT:
                    begin
                        if (printable)
                        begin
                            wmode_next  = tcfb_pkg::W_GLYPH;
                            wx0_next    = CW'(cmd_reg.pos_x);
                            wy0_next    = CW'(cmd_reg.pos_y);
                            ww_next     = GW_C;
                            wh_next     = GH_C;
                            wcolor_next = cmd_reg.color;
                            state_next  = tcfb_pkg::S_ROW;
                        end
                    end
                    default:
                        state_next = tcfb_pkg::S_DONE;
                endcase
            end

            tcfb_pkg::S_PC_CHK1:
            begin
                if (CW'(col_reg) + STEP_C > maxx)
                begin
                    ret_next   = tcfb_pkg::RET_CHK2;
                    state_next = tcfb_pkg::S_NL_START;
                end
                else
                    state_next = tcfb_pkg::S_PC_CHK2;
            end

            tcfb_pkg::S_PC_CHK2:
            begin
                if (CW'(row_reg) + GH_C > maxy)
                begin
                    ret_next   = tcfb_pkg::RET_DRAW;
                    state_next = tcfb_pkg::S_NL_START;
                end
                else
                    state_next = tcfb_pkg::S_PC_DRAW;
            end

            tcfb_pkg::S_PC_DRAW:
            begin
                nlw_next    = 1'b0;
                wmode_next  = tcfb_pkg::W_GLYPH;
                wx0_next    = CW'(col_reg);
                wy0_next    = CW'(row_reg);
                ww_next     = GW_C;
                wh_next     = GH_C;
                wcolor_next = cmd_reg.color;
                c_next      = '0;
                r_next      = '0;
                state_next  = tcfb_pkg::S_ROW;
            end

            tcfb_pkg::S_NL_START:
            begin
                col_next    = 11'(minx);
                nl_row_next = CW'(row_reg) + LH_C;
                sacc_next   = '0;
                state_next  = tcfb_pkg::S_NL_LOOP;
            end

            // one scroll step per cycle until the glyph fits
            tcfb_pkg::S_NL_LOOP:
            begin
                if (nl_sum > (CW+1)'(limit) && nl_row_reg >= LH_C)
                begin
                    nl_row_next = nl_row_reg - LH_C;
                    sacc_next   = sacc_reg + LH_C;
                end
                else
                begin
                    row_next   = nl_row_reg[10:0];
                    state_next = ret_state;
                    if (sacc_reg != '0)
                    begin
                        scr_next = 1'b1;
                        c_next   = '0;
                        r_next   = '0;
                        nlw_next = 1'b1;
                        wmode_next = tcfb_pkg::W_COPY;
                        if (!cfg.clip_on)
                        begin
                            s_next      = s_scr;
                            wx0_next    = '0;
                            wy0_next    = '0;
                            ww_next     = CW'(cfg.scan_stride);
                            wh_next     = SH_C - s_scr;
                            wcolor_next = bg_reg;
                            state_next  = tcfb_pkg::S_ROW;
                        end
                        else if (cfg.clip_w != '0 && CW'(cfg.clip_h) > LH_C)
                        begin
                            s_next      = s_clip;
                            wx0_next    = CW'(cfg.clip_x);
                            wy0_next    = CW'(cfg.clip_y);
                            ww_next     = CW'(cfg.clip_w);
                            wh_next     = CW'(cfg.clip_h) - s_clip;
                            wcolor_next = cfg.clip_background;
                            state_next  = tcfb_pkg::S_ROW;
                        end
                    end
                end
            end

            tcfb_pkg::S_ROW:
            begin
                c_next = '0;
                if (r_reg >= wh_reg || ww_reg == '0)
                    state_next = tcfb_pkg::S_WEND;
                else
                begin
                    if (wmode_reg == tcfb_pkg::W_GLYPH)
                    begin
                        font_req.en   = 1'b1;
                        font_req.addr = {glyph_base, r_reg[3:0]};
                    end
                    state_next = tcfb_pkg::S_PIX;
                end
            end

            tcfb_pkg::S_PIX:
            begin
                if (wmode_reg == tcfb_pkg::W_COPY)
                begin
                    fs_en      = addr_ok;
                    rdok_next  = addr_ok;
                    state_next = tcfb_pkg::S_CPW;
                end
                else
                begin
                    unique case (wmode_reg)
                        tcfb_pkg::W_CLIPPED: fs_we = addr_ok && on_scr;
                        tcfb_pkg::W_GLYPH:   fs_we = addr_ok && on_scr && glyph_bit;
                        default:             fs_we = addr_ok;
                    endcase
                    fs_en = fs_we;
                    if (last_col)
                    begin
                        r_next     = r_reg + CW'(1);
                        state_next = tcfb_pkg::S_ROW;
                    end
                    else
                        c_next = c_reg + CW'(1);
                end
            end

            tcfb_pkg::S_CPW:
            begin
                fs_we    = addr_ok;
                fs_en    = addr_ok;
                fs_wdata = rdok_reg ? fs_q : '0;
                if (last_col)
                begin
                    r_next     = r_reg + CW'(1);
                    state_next = tcfb_pkg::S_ROW;
                end
                else
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = tcfb_pkg::S_PIX;
                end
            end

            tcfb_pkg::S_WEND:
            begin
                if (wmode_reg == tcfb_pkg::W_COPY)
                begin
                    // copy done: free rows right below get the fill color
                    wmode_next = tcfb_pkg::W_RAW;
                    wy0_next   = wy0_reg + wh_reg;
                    wh_next    = s_reg;
                    r_next     = '0;
                    state_next = tcfb_pkg::S_ROW;
                end
                else if (nlw_reg)
                    state_next = ret_state;
                else
                begin
                    if (kind == tcfb_pkg::KIND_PUT)
                        col_next = col_reg + 11'(STEP_C);
                    state_next = tcfb_pkg::S_DONE;
                end
            end

            tcfb_pkg::S_RD:
            begin
                rdok_next  = addr_ok && on_scr;
                fs_en      = addr_ok && on_scr;
                state_next = tcfb_pkg::S_RDW;
            end

            tcfb_pkg::S_RDW:
            begin
                pix_next   = rdok_reg ? fs_q : '0;
                state_next = tcfb_pkg::S_DONE;
            end

            tcfb_pkg::S_DONE:
            begin
                res_next.done        = 1'b1;
                res_next.pixel_value = pix_reg;
                res_next.cursor_x    = col_reg;
                res_next.cursor_y    = row_reg;
                res_next.scrolled    = scr_reg;
                state_next           = tcfb_pkg::S_IDLE;
            end

            default:
                state_next = tcfb_pkg::S_IDLE;
        endcase
    end

    assign busy    = state_reg != tcfb_pkg::S_IDLE;
    assign res     = res_reg;
    assign fs_addr = addr_full[FS_AW-1:0];

    `TCFB_ASSERT_NEXT(a_done_after_finish, state_reg == tcfb_pkg::S_DONE, res_reg.done && !busy, "result strobe missing after finish")
    `TCFB_ASSERT_NOW(a_idle_no_store_access, state_reg == tcfb_pkg::S_IDLE, !fs_en && !font_req.en, "store access while idle")
    `TCFB_ASSERT_NOW(a_write_in_range, fs_we, addr_ok && fs_en, "frame store write beyond depth")
    `TCFB_ASSERT_NOW(a_copy_follows_read, state_reg == tcfb_pkg::S_CPW, $past(state_reg) == tcfb_pkg::S_PIX, "copy write without prior read")

endmodule

/* hdl/text_console_framebuffer_unit.sv */
// flow: a command is taken in idle and decoded; put char checks the column, then the row,
// starts a new line where the glyph does not fit, draws it and advances the column. A new
// line moves the row down a line and steps it back up while it overflows, then scrolls the
// screen or clip window up and fills the freed rows. Fill, erase, clear and char at walk
// the store row by row; a pixel read reads it once. One command at a time; done pulses once.
// reset clears cursor, background and state; frame and font stores stay undefined.
module text_console_framebuffer_unit #(
    parameter int SCREEN_WIDTH  = tcfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_WIDTH   = tcfb_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT  = tcfb_pkg::GLYPH_HEIGHT_DEF,
    parameter int LINE_GAP      = tcfb_pkg::LINE_GAP_DEF,
    parameter int CHAR_GAP      = tcfb_pkg::CHAR_GAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [3:0]  kind,
    input  logic [9:0]  pos_x,
    input  logic [9:0]  pos_y,
    input  logic [10:0] rect_w,
    input  logic [10:0] rect_h,
    input  logic [7:0]  char_code,
    input  logic [31:0] color,
    input  logic [3:0]  font_row,
    input  logic [7:0]  font_bits,
    output logic [31:0] pixel_value,
    output logic [10:0] cursor_x,
    output logic [10:0] cursor_y,
    output logic        scrolled,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int FS_DEPTH = SCREEN_HEIGHT * 1024;
    localparam int FS_AW    = $clog2(FS_DEPTH);

    tcfb_pkg::cfg_t      cfg_reg;
    tcfb_pkg::cmd_t      cmd;
    tcfb_pkg::res_t      res;
    tcfb_pkg::font_req_t font_req;
    logic                fs_en, fs_we;
    logic [FS_AW-1:0]    fs_addr;
    logic [31:0]         fs_wdata, fs_q;
    logic [7:0]          font_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= {tcfb_pkg::STRIDE_RESET, 71'd0};
        else if (cfg_valid && cfg_ready)
        begin
            case (tcfb_pkg::cfg_idx_t'(cfg_index))
                tcfb_pkg::CFG_SCAN_STRIDE: cfg_reg.scan_stride     <= cfg_data[10:0];
                tcfb_pkg::CFG_CLIP_ON:     cfg_reg.clip_on         <= cfg_data[0];
                tcfb_pkg::CFG_CLIP_X:      cfg_reg.clip_x          <= cfg_data[9:0];
                tcfb_pkg::CFG_CLIP_Y:      cfg_reg.clip_y          <= cfg_data[8:0];
                tcfb_pkg::CFG_CLIP_W:      cfg_reg.clip_w          <= cfg_data[9:0];
                tcfb_pkg::CFG_CLIP_H:      cfg_reg.clip_h          <= cfg_data[8:0];
                tcfb_pkg::CFG_CLIP_BG:     cfg_reg.clip_background <= cfg_data;
                default:                   cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd.kind      = kind;
        cmd.pos_x     = pos_x;
        cmd.pos_y     = pos_y;
        cmd.rect_w    = rect_w;
        cmd.rect_h    = rect_h;
        cmd.char_code = char_code;
        cmd.color     = color;
        cmd.font_row  = font_row;
        cmd.font_bits = font_bits;
    end

    tcfb_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_WIDTH   (GLYPH_WIDTH),
        .GLYPH_HEIGHT  (GLYPH_HEIGHT),
        .LINE_GAP      (LINE_GAP),
        .CHAR_GAP      (CHAR_GAP),
        .FS_DEPTH      (FS_DEPTH),
        .FS_AW         (FS_AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .busy     (busy),
        .res      (res),
        .fs_en    (fs_en),
        .fs_we    (fs_we),
        .fs_addr  (fs_addr),
        .fs_wdata (fs_wdata),
        .fs_q     (fs_q),
        .font_req (font_req),
        .font_q   (font_q)
    );

    tcfb_spram #(
        .WIDTH (32),
        .DEPTH (FS_DEPTH),
        .AW    (FS_AW)
    ) u_frame_mem (
        .clk   (clk),
        .en    (fs_en),
        .we    (fs_we),
        .addr  (fs_addr),
        .wdata (fs_wdata),
        .rdata (fs_q)
    );

    tcfb_spram #(
        .WIDTH (8),
        .DEPTH (tcfb_pkg::FONT_DEPTH),
        .AW    (tcfb_pkg::FONT_AW)
    ) u_font_mem (
        .clk   (clk),
        .en    (font_req.en),
        .we    (font_req.we),
        .addr  (font_req.addr),
        .wdata (font_req.wdata),
        .rdata (font_q)
    );

    assign done        = res.done;
    assign pixel_value = res.pixel_value;
    assign cursor_x    = res.cursor_x;
    assign cursor_y    = res.cursor_y;
    assign scrolled    = res.scrolled;

endmodule
